### src/huffman_code_packer_top_macros.svh
// assertion macros used by the port checker
`ifndef HUFFMAN_CODE_PACKER_TOP_MACROS_SVH
`define HUFFMAN_CODE_PACKER_TOP_MACROS_SVH

// assertion that is switched off while reset is held
`define HCP_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("huffman code packer check failed");

// assertion that also watches the reset cycles
`define HCP_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("huffman code packer check failed");

`endif

### src/hcp_pkg.sv
// package with the shared types and constants of the huffman code packer
`timescale 1ns / 1ps

package hcp_pkg;

    localparam int CMD_W      = 2;
    localparam int SYM_IN_W   = 8;
    localparam int LEN_W      = 6;
    localparam int CODE_W     = 56;
    localparam int BYTE_W     = 8;
    localparam int PEND_W     = 3;
    localparam int ACC_W      = BYTE_W + CODE_W;
    localparam int TOT_W      = 6;
    localparam int IN_TDATA_W = 72;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    // command codes carried in the input tuser
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

    // one unit of work for the packer; code is left-aligned in CODE_W bits
    typedef struct packed {
        logic              is_flush;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } hcp_entry_t;

    typedef struct packed {
        logic       valid;
        hcp_entry_t entry;
    } hcp_push_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_FLUSH_DATA,
        BK_FLUSH_COUNT
    } hcp_bk_state_t;

endpackage

### src/hcp_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module hcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/hcp_front.sv
// front end: accepts requests, keeps the code table and looks up symbols
`timescale 1ns / 1ps

module hcp_front #(
    parameter int MAX_CODE_LEN = 56,
    parameter int SYMBOLS      = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hcp_pkg::CMD_W-1:0]      command,
    input  logic [hcp_pkg::SYM_IN_W-1:0]   symbol,
    input  logic [hcp_pkg::LEN_W-1:0]      code_length,
    input  logic [hcp_pkg::CODE_W-1:0]     code_value,
    output hcp_pkg::hcp_push_t             push_o,
    input  logic                           push_full
);

    localparam int SYM_W = $clog2(SYMBOLS);
    localparam int RAM_W = hcp_pkg::LEN_W + MAX_CODE_LEN;

    logic                         accept;
    logic                         in_range;
    logic [SYM_W-1:0]             addr;
    logic                         we;
    logic                         re;
    logic [hcp_pkg::LEN_W-1:0]    len_sat;
    logic [hcp_pkg::LEN_W-1:0]    align_sh;
    logic [MAX_CODE_LEN-1:0]      val_trim;
    logic [MAX_CODE_LEN-1:0]      code_left;
    logic [RAM_W-1:0]             rdata;

    logic [SYMBOLS-1:0]           known_reg;
    logic                         b_valid_reg;
    logic                         b_valid_next;
    logic                         b_flush_reg;
    logic                         b_flush_next;
    logic                         b_hit_reg;
    logic                         b_hit_next;

    logic [hcp_pkg::LEN_W-1:0]    b_len;
    logic [MAX_CODE_LEN-1:0]      b_code;
    logic                         b_push;
    logic                         b_drop;
    logic                         b_leave;

    assign accept   = s_tvalid && s_tready;
    assign in_range = {1'b0, symbol} < (hcp_pkg::SYM_IN_W + 1)'(SYMBOLS);
    assign addr     = symbol[SYM_W-1:0];

    // saturate the length, then left-align the code and shed stray bits
    assign len_sat  = (code_length > hcp_pkg::LEN_W'(MAX_CODE_LEN))
                      ? hcp_pkg::LEN_W'(MAX_CODE_LEN) : code_length;
    assign align_sh = hcp_pkg::LEN_W'(MAX_CODE_LEN) - len_sat;
    assign val_trim = code_value[MAX_CODE_LEN-1:0];
    assign code_left = val_trim << align_sh;

    assign we = accept && (command == hcp_pkg::CMD_LOAD) && in_range;
    assign re = accept && (command == hcp_pkg::CMD_ENCODE);

    hcp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SYMBOLS)
    ) u_table (
        .clk   (aclk),
        .we    (we),
        .waddr (addr),
        .wdata ({len_sat, code_left}),
        .re    (re),
        .raddr (addr),
        .rdata (rdata)
    );

    // lookup stage
    assign b_len  = b_hit_reg ? rdata[RAM_W-1 -: hcp_pkg::LEN_W] : '0;
    assign b_code = rdata[MAX_CODE_LEN-1:0];
    assign b_drop = b_valid_reg && !b_flush_reg && (b_len == '0);
    assign b_push = b_valid_reg && !b_drop && !push_full;
    assign b_leave = b_push || b_drop;
    assign s_tready = !b_valid_reg || b_leave;

    always_comb begin
        push_o.valid          = b_push;
        push_o.entry.is_flush = b_flush_reg;
        push_o.entry.len      = b_len;
        push_o.entry.code     = hcp_pkg::CODE_W'(b_code) << (hcp_pkg::CODE_W - MAX_CODE_LEN);
    end

    always_comb begin
        b_valid_next = b_valid_reg;
        b_flush_next = b_flush_reg;
        b_hit_next   = b_hit_reg;
        if (accept) begin
            b_valid_next = (command == hcp_pkg::CMD_ENCODE) || (command == hcp_pkg::CMD_FLUSH);
            b_flush_next = (command == hcp_pkg::CMD_FLUSH);
            b_hit_next   = in_range && known_reg[addr];
        end else if (b_leave) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            known_reg   <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
            if (we) begin
                known_reg[addr] <= 1'b1;
            end
        end
        b_flush_reg <= b_flush_next;
        b_hit_reg   <= b_hit_next;
    end

endmodule

### src/hcp_queue.sv
// two-entry queue between the lookup front end and the packer
`timescale 1ns / 1ps

module hcp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  hcp_pkg::hcp_push_t push_i,
    output logic               full,
    output hcp_pkg::hcp_push_t head_o,
    input  logic               pop
);

    hcp_pkg::hcp_entry_t             mem_reg [hcp_pkg::Q_DEPTH];
    logic [hcp_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [hcp_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [hcp_pkg::Q_CNT_W-1:0]     count_reg;
    logic [hcp_pkg::Q_CNT_W-1:0]     count_next;

    assign full         = (count_reg == hcp_pkg::Q_CNT_W'(hcp_pkg::Q_DEPTH));
    assign head_o.valid = (count_reg != '0);
    assign head_o.entry = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        unique case ({push_i.valid, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_i.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
        if (push_i.valid) begin
            mem_reg[wr_ptr_reg] <= push_i.entry;
        end
    end

endmodule

### src/hcp_back.sv
// back end: bit accumulator that cuts codes into bytes and drives the output
`timescale 1ns / 1ps

module hcp_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  hcp_pkg::hcp_push_t          head_i,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [hcp_pkg::BYTE_W-1:0]  m_tdata,
    output logic                        m_tlast
);

    hcp_pkg::hcp_bk_state_t           state_reg;
    hcp_pkg::hcp_bk_state_t           state_next;
    logic [hcp_pkg::ACC_W-1:0]        acc_reg;
    logic [hcp_pkg::ACC_W-1:0]        acc_next;
    logic [hcp_pkg::TOT_W-1:0]        tot_reg;
    logic [hcp_pkg::TOT_W-1:0]        tot_next;
    logic                             m_valid_reg;
    logic                             m_valid_next;
    logic [hcp_pkg::BYTE_W-1:0]       m_byte_reg;
    logic                             m_last_reg;

    logic                             out_free;
    logic                             out_load;
    logic [hcp_pkg::BYTE_W-1:0]       out_byte;
    logic                             out_last;
    logic [hcp_pkg::ACC_W-1:0]        base_acc;
    logic [hcp_pkg::TOT_W-1:0]        base_tot;
    logic [hcp_pkg::ACC_W-1:0]        code_ext;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        tot_next   = tot_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        out_byte   = '0;
        out_last   = 1'b0;
        base_acc   = acc_reg;
        base_tot   = tot_reg;
        code_ext   = '0;
        unique case (state_reg)
            hcp_pkg::BK_RUN: begin
                // emit a full byte from the top of the accumulator
                if ((tot_reg >= hcp_pkg::TOT_W'(hcp_pkg::BYTE_W)) && out_free) begin
                    out_load = 1'b1;
                    out_byte = acc_reg[hcp_pkg::ACC_W-1 -: hcp_pkg::BYTE_W];
                    out_last = tot_reg < hcp_pkg::TOT_W'(2 * hcp_pkg::BYTE_W);
                    base_acc = acc_reg << hcp_pkg::BYTE_W;
                    base_tot = tot_reg - hcp_pkg::TOT_W'(hcp_pkg::BYTE_W);
                end
                acc_next = base_acc;
                tot_next = base_tot;
                // take the next entry once only partial bits remain
                if (head_i.valid && (base_tot < hcp_pkg::TOT_W'(hcp_pkg::BYTE_W))) begin
                    pop = 1'b1;
                    if (head_i.entry.is_flush) begin
                        if (base_tot != '0) begin
                            state_next = hcp_pkg::BK_FLUSH_DATA;
                        end
                    end else begin
                        code_ext = {head_i.entry.code, hcp_pkg::BYTE_W'(0)}
                                   >> base_tot[hcp_pkg::PEND_W-1:0];
                        acc_next = base_acc | code_ext;
                        tot_next = base_tot + hcp_pkg::TOT_W'(head_i.entry.len);
                    end
                end
            end
            hcp_pkg::BK_FLUSH_DATA: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_byte   = acc_reg[hcp_pkg::ACC_W-1 -: hcp_pkg::BYTE_W]
                                 >> (4'(hcp_pkg::BYTE_W) - {1'b0, tot_reg[hcp_pkg::PEND_W-1:0]});
                    state_next = hcp_pkg::BK_FLUSH_COUNT;
                end
            end
            hcp_pkg::BK_FLUSH_COUNT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_byte   = hcp_pkg::BYTE_W'(tot_reg[hcp_pkg::PEND_W-1:0]);
                    out_last   = 1'b1;
                    acc_next   = '0;
                    tot_next   = '0;
                    state_next = hcp_pkg::BK_RUN;
                end
            end
            default: begin
                state_next = hcp_pkg::BK_RUN;
            end
        endcase
    end

    assign m_valid_next = out_free ? out_load : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hcp_pkg::BK_RUN;
            acc_reg     <= '0;
            tot_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            tot_reg     <= tot_next;
            m_valid_reg <= m_valid_next;
        end
        if (out_load) begin
            m_byte_reg <= out_byte;
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tlast  = m_last_reg;

endmodule

### src/huffman_code_packer_top.sv
// top level of the huffman code packer: table lookup, queue and byte packer
//
//  channel | dir | tdata (low bit up)                               | tuser   | tlast
//  --------+-----+--------------------------------------------------+---------+------------
//  s_      | in  | symbol[7:0], code_length[13:8], code_value[69:14] | command | -
//  m_      | out | packed_byte[7:0]                                  | -       | last
//
// - one request per cycle enters while the lookup stage can pass it on; an encode
//   adds its code to the packer, which shifts out one byte a cycle unless the output stalls
// - a flush with pending bits walks BK_FLUSH_DATA and BK_FLUSH_COUNT: tail byte, count byte
// - a load only writes the table ram and never reaches the packer
// - reset clears the code-present bits at once: no clearing pass
// - a stalled output holds the packer; the two-entry queue and lookup stage
//   keep taking requests until both are full
`timescale 1ns / 1ps

module huffman_code_packer_top #(
    parameter int MAX_CODE_LEN = 56,
    parameter int SYMBOLS      = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // symbol, code_length, code_value, zero fill
    input  logic [hcp_pkg::IN_TDATA_W-1:0]    s_tdata,
    // command
    input  logic [hcp_pkg::CMD_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // packed_byte
    output logic [hcp_pkg::BYTE_W-1:0]        m_tdata,
    output logic                              m_tlast
);

    localparam int LEN_LO  = hcp_pkg::SYM_IN_W;
    localparam int CODE_LO = hcp_pkg::SYM_IN_W + hcp_pkg::LEN_W;

    hcp_pkg::hcp_push_t push;
    hcp_pkg::hcp_push_t head;
    logic               q_full;
    logic               q_pop;

    // lookup front end; code table lives here
    hcp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOLS      (SYMBOLS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .command     (s_tuser),
        .symbol      (s_tdata[hcp_pkg::SYM_IN_W-1:0]),
        .code_length (s_tdata[LEN_LO +: hcp_pkg::LEN_W]),
        .code_value  (s_tdata[CODE_LO +: hcp_pkg::CODE_W]),
        .push_o      (push),
        .push_full   (q_full)
    );

    // decouples lookup from output backpressure
    hcp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .full    (q_full),
        .head_o  (head),
        .pop     (q_pop)
    );

    // bit accumulator and output register
    hcp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_i   (head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### src/hcp_checker.sv
// port checker for the huffman code packer and its bind
`timescale 1ns / 1ps
`include "huffman_code_packer_top_macros.svh"

module hcp_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [hcp_pkg::BYTE_W-1:0] m_tdata,
    input logic                       m_tlast
);

    // a stalled result stays offered
    `HCP_ASSERT_RST(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid)

    // a stalled result keeps its byte and last flag
    `HCP_ASSERT_RST(a_out_stable, aclk, aresetn, (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))

    // reset empties the output register
    `HCP_ASSERT(a_rst_out_idle, aclk, !aresetn |=> !m_tvalid)

    // reset empties the lookup stage, so requests are taken right away
    `HCP_ASSERT(a_rst_ready, aclk, !aresetn |=> s_tready)

endmodule

bind huffman_code_packer_top hcp_checker u_hcp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### bench/packed_byte_checker.sv
// checker for the huffman code packer: predicts the packed byte stream and compares it
`timescale 1ns / 1ps

module packed_byte_checker #(
    parameter int MAX_CODE_LEN = 56,
    parameter int SYMBOLS      = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // symbol, code_length, code_value, zero fill
    input  logic [hcp_pkg::IN_TDATA_W-1:0] s_tdata,
    // command
    input  logic [hcp_pkg::CMD_W-1:0]      s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // packed_byte
    input  logic [hcp_pkg::BYTE_W-1:0]     m_tdata,
    input  logic                           m_tlast,
    output int                             mismatch_count,
    output int                             bytes_owed,
    output int                             bytes_checked
);

    typedef struct packed {
        logic [hcp_pkg::BYTE_W-1:0] packed_byte;
        logic                       last_flag;
    } out_byte_t;

    logic [hcp_pkg::LEN_W-1:0]  len_tbl [256];
    logic [hcp_pkg::CODE_W-1:0] code_tbl [256];
    logic [6:0]                 held_bits;
    int unsigned                held_count;
    out_byte_t                  expected_bytes [$];
    int                         errs = 0;
    int                         checked = 0;

    // table update for a load, bit packing for an encode, tail bytes for a flush
    task automatic predict_packed_bytes(input logic [hcp_pkg::CMD_W-1:0] cmd,
                                        input logic [7:0] sym,
                                        input logic [hcp_pkg::LEN_W-1:0] len,
                                        input logic [hcp_pkg::CODE_W-1:0] val);
        logic [63:0] acc;
        int unsigned clen;
        int unsigned total;
        int unsigned nbytes;
        out_byte_t   ob;
        unique case (cmd)
            hcp_pkg::CMD_LOAD: begin
                if (sym < SYMBOLS) begin
                    clen = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : len;
                    len_tbl[sym]  = clen[hcp_pkg::LEN_W-1:0];
                    code_tbl[sym] = hcp_pkg::CODE_W'(val & ((64'd1 << clen) - 64'd1));
                end
            end
            hcp_pkg::CMD_ENCODE: begin
                if (sym < SYMBOLS && len_tbl[sym] != 0) begin
                    clen   = len_tbl[sym];
                    acc    = (64'(held_bits) << clen) | 64'(code_tbl[sym]);
                    total  = held_count + clen;
                    nbytes = total / 8;
                    for (int k = 1; k <= nbytes; k++) begin
                        total          = total - 8;
                        ob.packed_byte = 8'(acc >> total);
                        ob.last_flag   = (k == nbytes);
                        expected_bytes = {expected_bytes, ob};
                    end
                    held_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
                    held_count = total;
                end
            end
            hcp_pkg::CMD_FLUSH: begin
                if (held_count != 0) begin
                    ob.packed_byte = {1'b0, held_bits};
                    ob.last_flag   = 1'b0;
                    expected_bytes = {expected_bytes, ob};
                    ob.packed_byte = 8'(held_count);
                    ob.last_flag   = 1'b1;
                    expected_bytes = {expected_bytes, ob};
                    held_bits  = '0;
                    held_count = 0;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin : watch
        out_byte_t ob;
        if (!aresetn) begin
            for (int k = 0; k < 256; k++) begin
                len_tbl[k]  = '0;
                code_tbl[k] = '0;
            end
            held_bits  = '0;
            held_count = 0;
            expected_bytes.delete();
        end else begin
            // output first: a byte leaving now cannot stem from a request taken now
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: unexpected output byte %02h last %0b",
                                 $realtime, m_tdata, m_tlast);
                end else begin
                    ob = expected_bytes.pop_front();
                    checked++;
                    if (ob.packed_byte !== m_tdata || ob.last_flag !== m_tlast) begin
                        errs++;
                        if (errs <= 10)
                            $display("%0t: byte mismatch: expected %02h last %0b, %s %02h last %0b",
                                     $realtime, ob.packed_byte, ob.last_flag, "got",
                                     m_tdata, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_packed_bytes(s_tuser, s_tdata[7:0], s_tdata[13:8], s_tdata[69:14]);
        end
        mismatch_count <= errs;
        bytes_owed     <= expected_bytes.size();
        bytes_checked  <= checked;
    end

endmodule

### bench/testbench.sv
// testbench top for the huffman code packer: stimulus, flow control and verdict
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_REQS = 80;
    localparam int CALM_FROM   = 60;

    // the one command code the block ignores
    localparam logic [hcp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [hcp_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic [hcp_pkg::CMD_W-1:0]      s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [hcp_pkg::BYTE_W-1:0]     m_tdata;
    logic                           m_tlast;

    int mismatch_count;
    int bytes_owed;
    int bytes_checked;

    bit          calm = 1'b0;
    int          stall_left = 0;
    int          cycle_count = 0;
    int          loads = 0;
    int          encodes = 0;
    int          flushes = 0;
    int          ignored = 0;
    logic [7:0]  alphabet [16];

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    huffman_code_packer_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    packed_byte_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .bytes_owed     (bytes_owed),
        .bytes_checked  (bytes_checked)
    );

    // watchdog against a hung handshake
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still owed",
                     cycle_count, bytes_owed);
            $display("Test completed with failures");
            $finish;
        end
    end

    // output backpressure: random stall bursts, none in the calm tail
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 10);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [hcp_pkg::CODE_W-1:0] random_code();
        return hcp_pkg::CODE_W'({$urandom(), $urandom()});
    endfunction

    // mostly short codes, some long ones, a few overlong and a few empty
    function automatic logic [hcp_pkg::LEN_W-1:0] random_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return hcp_pkg::LEN_W'($urandom_range(1, 12));
        else if (r < 85)
            return hcp_pkg::LEN_W'($urandom_range(13, 40));
        else if (r < 93)
            return hcp_pkg::LEN_W'($urandom_range(41, 56));
        else if (r < 97)
            return hcp_pkg::LEN_W'($urandom_range(57, 63));
        return '0;
    endfunction

    // present one request and hold it until the block takes it
    task automatic send_request(input logic [hcp_pkg::CMD_W-1:0] cmd,
                                input logic [7:0] sym,
                                input logic [hcp_pkg::LEN_W-1:0] len,
                                input logic [hcp_pkg::CODE_W-1:0] val);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, val, len, sym};
        do @(posedge aclk); while (!s_tready);
        unique case (cmd)
            hcp_pkg::CMD_LOAD:   loads++;
            hcp_pkg::CMD_ENCODE: encodes++;
            hcp_pkg::CMD_FLUSH:  flushes++;
            default:             ignored++;
        endcase
    endtask

    // hold off the sender until every predicted byte has come out
    task automatic drain_output();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (bytes_owed != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int r;
        logic [7:0] sym;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table, empty buffer, ignored command
        send_request(hcp_pkg::CMD_ENCODE, 8'h41, '0, '0);
        send_request(hcp_pkg::CMD_FLUSH, 8'h00, '0, '0);
        send_request(CMD_UNUSED, 8'h00, '0, '0);
        // stray value bits, longest code, overlong length, explicit no-code, one bit
        send_request(hcp_pkg::CMD_LOAD, 8'h41, 6'd3, 56'hFF_FFFF_FFFF_FFF5);
        send_request(hcp_pkg::CMD_LOAD, 8'hFF, 6'd56, '1);
        send_request(hcp_pkg::CMD_LOAD, 8'h00, 6'd63, 56'hA5_A5A5_A5A5_A5A5);
        send_request(hcp_pkg::CMD_LOAD, 8'h10, 6'd0, 56'h12_3456_789A_BCDE);
        send_request(hcp_pkg::CMD_LOAD, 8'h80, 6'd1, 56'd1);
        // 3 bits pending, then two 56-bit codes give seven bytes each
        send_request(hcp_pkg::CMD_ENCODE, 8'h41, '0, '0);
        send_request(hcp_pkg::CMD_ENCODE, 8'hFF, '0, '0);
        send_request(hcp_pkg::CMD_ENCODE, 8'h00, '0, '0);
        send_request(hcp_pkg::CMD_ENCODE, 8'h10, '0, '0);
        send_request(hcp_pkg::CMD_FLUSH, 8'h00, '0, '0);
        send_request(hcp_pkg::CMD_FLUSH, 8'h00, '0, '0);
        // seven single bits leave the buffer one short of a byte
        repeat (7) send_request(hcp_pkg::CMD_ENCODE, 8'h80, '0, '0);
        send_request(hcp_pkg::CMD_FLUSH, 8'h00, '0, '0);
        send_request(CMD_UNUSED, 8'hFF, 6'h3F, '1);
        drain_output();

        // a small alphabet with real codes, then streams over it
        foreach (alphabet[i]) begin
            alphabet[i] = 8'($urandom_range(0, 255));
            send_request(hcp_pkg::CMD_LOAD, alphabet[i],
                         hcp_pkg::LEN_W'($urandom_range(1, 12)), random_code());
        end

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == CALM_FROM)
                calm = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 12) begin
                sym = ($urandom_range(0, 3) != 0) ? alphabet[$urandom_range(0, 15)]
                                                 : 8'($urandom_range(0, 255));
                send_request(hcp_pkg::CMD_LOAD, sym, random_length(), random_code());
            end else if (r < 82) begin
                sym = ($urandom_range(0, 9) != 0) ? alphabet[$urandom_range(0, 15)]
                                                 : 8'($urandom_range(0, 255));
                // unused fields carry noise on an encode
                send_request(hcp_pkg::CMD_ENCODE, sym, hcp_pkg::LEN_W'($urandom()),
                             random_code());
            end else if (r < 95) begin
                send_request(hcp_pkg::CMD_FLUSH, 8'($urandom()),
                             hcp_pkg::LEN_W'($urandom()), random_code());
                if (!calm && $urandom_range(0, 3) == 0)
                    drain_output();
            end else begin
                send_request(CMD_UNUSED, 8'($urandom()), hcp_pkg::LEN_W'($urandom()),
                             random_code());
            end
        end

        // close the last run so its tail bytes are checked too
        send_request(hcp_pkg::CMD_FLUSH, 8'h00, '0, '0);
        drain_output();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d loads, %0d encodes, %0d flushes, %0d ignored requests",
                 loads, encodes, flushes, ignored);
        $display("checked %0d packed bytes, %0d mismatches", bytes_checked, mismatch_count);
        if (mismatch_count == 0 && bytes_owed == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
